### rtl/wspf_pkg.sv
// Shared types, constants and the control program of the wheel speed PI controller.
// Used by wspf_seq, wspf_dp and wheel_speed_pi_with_filter; depends on nothing.
`default_nettype none

package wspf_pkg;

  // Default widths of the encoder count fields and of the state fraction.
  localparam int COUNT_WIDTH_DEF = 13;
  localparam int FRAC_BITS_DEF   = 8;

  // Gains are Q8.8 and the filter weight is Q1.8: both products drop 8 bits.
  localparam int       GAIN_SHIFT = 8;
  localparam int       ROUND_HALF = 128;
  localparam logic [8:0] COEF_ONE = 9'd256;

  // Register reset values.
  localparam logic [15:0] KP_RESET      = 16'd8960;
  localparam logic [15:0] KI_RESET      = 16'd1280;
  localparam logic [8:0]  FILT_RESET    = 9'd77;
  localparam logic [14:0] DRIVE_RESET   = 15'd4000;
  localparam logic [11:0] DEAD_RESET    = 12'd150;
  localparam logic [11:0] SPEED_RESET   = 12'd4095;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_FILT   = 3'd2,
    REG_DRIVE  = 3'd3,
    REG_DEAD   = 3'd4,
    REG_SPEED  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [8:0]  filter_coeff;
    logic [14:0] drive_limit;
    logic [11:0] dead_zone;
    logic [11:0] target_max;
  } cfg_t;

  // One result word: drive, pwm_level, saturated.
  localparam int OUT_FIELDS_W = 33;
  localparam int OUT_TDATA_W  = 40;

  typedef struct packed {
    logic        saturated;
    logic [15:0] pwm_level;
    logic [15:0] drive;
  } res_t;

  // Datapath selections driven by the control word.
  typedef enum logic [1:0] {
    A_COEF     = 2'd0,
    A_COEF_INV = 2'd1,
    A_KP       = 2'd2,
    A_KI       = 2'd3
  } a_sel_t;

  typedef enum logic [1:0] {
    B_MEAS = 2'd0,
    B_FILT = 2'd1,
    B_DERR = 2'd2,
    B_ERR  = 2'd3
  } b_sel_t;

  typedef enum logic [1:0] {
    MAC_HOLD = 2'd0,
    MAC_LOAD = 2'd1,
    MAC_ADD  = 2'd2
  } mac_op_t;

  // Program addresses.
  typedef logic [3:0] step_t;

  localparam step_t STEP_MUL_NEW   = 4'd0;
  localparam step_t STEP_MUL_OLD   = 4'd1;
  localparam step_t STEP_FILT_SUM  = 4'd2;
  localparam step_t STEP_ERR       = 4'd3;
  localparam step_t STEP_MUL_P     = 4'd4;
  localparam step_t STEP_MUL_I     = 4'd5;
  localparam step_t STEP_PI_SUM    = 4'd6;
  localparam step_t STEP_ACC_ADD   = 4'd7;
  localparam step_t STEP_ACC_CLAMP = 4'd8;
  localparam step_t STEP_RESULT    = 4'd9;
  localparam step_t STEP_CLEAR     = 4'd10;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    mac_op_t mac_op;
    logic    ld_err;
    logic    ld_sum;
    logic    ld_acc;
    logic    clr;
    logic    last;
    logic    br_kind;
    step_t   jmp;
  } cw_t;

  localparam cw_t CW_NOP = '{
    a_sel:   A_COEF,
    b_sel:   B_MEAS,
    mac_op:  MAC_HOLD,
    ld_err:  1'b0,
    ld_sum:  1'b0,
    ld_acc:  1'b0,
    clr:     1'b0,
    last:    1'b0,
    br_kind: 1'b0,
    jmp:     STEP_MUL_NEW
  };

  // Control program. The multiplier result is registered, so the MAC takes
  // a product in the step after the step that selected its operands.
  function automatic cw_t ucode(input step_t pc);
    cw_t w;
    w = CW_NOP;
    case (pc)
      STEP_MUL_NEW: begin
        w.a_sel   = A_COEF;
        w.b_sel   = B_MEAS;
        w.br_kind = 1'b1;
        w.jmp     = STEP_CLEAR;
      end
      STEP_MUL_OLD: begin
        w.a_sel  = A_COEF_INV;
        w.b_sel  = B_FILT;
        w.mac_op = MAC_LOAD;
      end
      STEP_FILT_SUM:  w.mac_op = MAC_ADD;
      STEP_ERR:       w.ld_err = 1'b1;
      STEP_MUL_P: begin
        w.a_sel = A_KP;
        w.b_sel = B_DERR;
      end
      STEP_MUL_I: begin
        w.a_sel  = A_KI;
        w.b_sel  = B_ERR;
        w.mac_op = MAC_LOAD;
      end
      STEP_PI_SUM:    w.mac_op = MAC_ADD;
      STEP_ACC_ADD:   w.ld_sum = 1'b1;
      STEP_ACC_CLAMP: w.ld_acc = 1'b1;
      STEP_RESULT:    w.last   = 1'b1;
      STEP_CLEAR: begin
        w.clr  = 1'b1;
        w.last = 1'b1;
      end
      default:        w = CW_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/wspf_seq.sv
// Program counter and control store of the wheel speed PI controller.
// Depends on wspf_pkg for the control word type and the program.
`default_nettype none

module wspf_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            kind,
  input  wire logic            out_free,
  output wspf_pkg::cw_t        cw,
  output logic                 busy
);

  logic                busy_r, busy_nxt;
  wspf_pkg::step_t     pc_r, pc_nxt;
  logic                kind_r, kind_nxt;
  wspf_pkg::cw_t       rom_word;
  logic                hold_last;

  assign rom_word  = wspf_pkg::ucode(pc_r);
  assign busy      = busy_r;
  assign hold_last = rom_word.last && !out_free;

  // The last step waits until the output register can take the word.
  always_comb begin
    cw = wspf_pkg::CW_NOP;
    if (busy_r && !hold_last) begin
      cw = rom_word;
    end
  end

  // Step counter with the jump on a clear item; it stands still while the
  // last step waits.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    kind_nxt = kind_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = wspf_pkg::STEP_MUL_NEW;
      kind_nxt = kind;
    end else if (cw.last) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !hold_last) begin
      if (cw.br_kind && kind_r) begin
        pc_nxt = cw.jmp;
      end else begin
        pc_nxt = wspf_pkg::step_t'(pc_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= wspf_pkg::STEP_MUL_NEW;
      kind_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/wspf_dp.sv
// Datapath of the wheel speed PI controller: one shared multiplier, an
// accumulator, the controller state and the clamp and dead-zone logic.
// Depends on wspf_pkg; steered by the control word from wspf_seq.
`default_nettype none

module wspf_dp #(
  parameter int COUNT_WIDTH = wspf_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = wspf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic signed [COUNT_WIDTH-1:0] meas_in,
  input  wire logic signed [COUNT_WIDTH-1:0] target_in,
  input  wire wspf_pkg::cfg_t                cfg,
  input  wire wspf_pkg::cw_t                 cw,
  output wspf_pkg::res_t                     res
);

  localparam int CW      = COUNT_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int FS_W    = CW + F + 1;
  localparam int ERR_W   = CW + F + 2;
  localparam int MA_W    = 17;
  localparam int MB_W    = ERR_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int MAC_W   = PROD_W + 1;
  localparam int DELTA_W = MAC_W - wspf_pkg::GAIN_SHIFT;
  localparam int SUM_W   = DELTA_W + 1;
  localparam int ACC_W   = F + 17;
  localparam int CMP_W   = ((CW > 12) ? CW : 12) + 1;

  logic signed [CW-1:0]     meas_r, meas_nxt;
  logic signed [CW-1:0]     tgt_r, tgt_nxt;
  logic signed [FS_W-1:0]   fs_r, fs_nxt;
  logic signed [ERR_W-1:0]  prev_r, prev_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [FS_W-1:0]   filt_r, filt_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [MAC_W-1:0]  mac_r, mac_nxt;

  logic [8:0]               c_eff;
  logic [15:0]              ma_u;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [ERR_W:0]    derr;
  logic signed [MAC_W-1:0]  mac_rnd;
  logic signed [MAC_W-1:0]  mac_sh;
  logic signed [DELTA_W-1:0] delta;
  logic signed [CMP_W-1:0]  t_ext, sl_pos, sl_neg, t_clamp;
  logic signed [ACC_W-1:0]  lim, neg_lim;
  logic                     allow;
  logic                     neg;
  logic [ACC_W-1:0]         mag;
  logic [ACC_W-1:0]         dz_s;
  logic [15:0]              pwm_mag, pwm;
  logic                     in_dz;

  // Weight of the new sample, saturated at 1.0.
  assign c_eff = cfg.filter_coeff[8] ? wspf_pkg::COEF_ONE : cfg.filter_coeff;

  // Multiplier operand selection.
  assign derr = (ERR_W + 1)'(err_r) - (ERR_W + 1)'(prev_r);

  always_comb begin
    case (cw.a_sel)
      wspf_pkg::A_COEF:     ma_u = 16'(c_eff);
      wspf_pkg::A_COEF_INV: ma_u = 16'(wspf_pkg::COEF_ONE - c_eff);
      wspf_pkg::A_KP:       ma_u = cfg.kp_gain;
      wspf_pkg::A_KI:       ma_u = cfg.ki_gain;
      default:              ma_u = 16'd0;
    endcase
    case (cw.b_sel)
      wspf_pkg::B_MEAS: mb = MB_W'(meas_r) <<< F;
      wspf_pkg::B_FILT: mb = MB_W'(fs_r);
      wspf_pkg::B_DERR: mb = MB_W'(derr);
      wspf_pkg::B_ERR:  mb = MB_W'(err_r);
      default:          mb = '0;
    endcase
  end

  assign ma       = $signed({1'b0, ma_u});
  assign prod_nxt = ma * mb;

  // Product accumulator.
  always_comb begin
    case (cw.mac_op)
      wspf_pkg::MAC_LOAD: mac_nxt = MAC_W'(prod_r);
      wspf_pkg::MAC_ADD:  mac_nxt = mac_r + MAC_W'(prod_r);
      default:            mac_nxt = mac_r;
    endcase
  end

  // Round half up and drop the 8 fraction bits of the coefficient or gain.
  assign mac_rnd = mac_r + MAC_W'(wspf_pkg::ROUND_HALF);
  assign mac_sh  = mac_rnd >>> wspf_pkg::GAIN_SHIFT;
  assign delta   = mac_sh[DELTA_W-1:0];

  // Target clamp and speed error.
  assign t_ext  = CMP_W'(tgt_r);
  assign sl_pos = $signed(CMP_W'(cfg.target_max));
  assign sl_neg = -sl_pos;

  always_comb begin
    if (t_ext > sl_pos) begin
      t_clamp = sl_pos;
    end else if (t_ext < sl_neg) begin
      t_clamp = sl_neg;
    end else begin
      t_clamp = t_ext;
    end
  end

  always_comb begin
    filt_nxt = filt_r;
    err_nxt  = err_r;
    if (cw.ld_err) begin
      filt_nxt = mac_sh[FS_W-1:0];
      err_nxt  = (ERR_W'(t_clamp) <<< F) - ERR_W'($signed(mac_sh[FS_W-1:0]));
    end
  end

  // Anti-windup: the increment is refused when it pushes further into the limit.
  assign lim     = $signed(ACC_W'(cfg.drive_limit) << F);
  assign neg_lim = -lim;
  assign allow   = !((acc_r >= lim && delta > 0) || (acc_r <= neg_lim && delta < 0));

  always_comb begin
    sum_nxt = sum_r;
    if (cw.ld_sum) begin
      sum_nxt = allow ? (SUM_W'(acc_r) + SUM_W'(delta)) : SUM_W'(acc_r);
    end
  end

  // Accumulator clamp and state update; a clear item zeroes the state.
  always_comb begin
    acc_nxt  = acc_r;
    prev_nxt = prev_r;
    fs_nxt   = fs_r;
    if (cw.clr) begin
      acc_nxt  = '0;
      prev_nxt = '0;
      fs_nxt   = '0;
    end else if (cw.ld_acc) begin
      if (sum_r > SUM_W'(lim)) begin
        acc_nxt = lim;
      end else if (sum_r < SUM_W'(neg_lim)) begin
        acc_nxt = neg_lim;
      end else begin
        acc_nxt = sum_r[ACC_W-1:0];
      end
      prev_nxt = err_r;
      fs_nxt   = filt_r;
    end
  end

  // Input word capture.
  assign meas_nxt = load ? meas_in : meas_r;
  assign tgt_nxt  = load ? target_in : tgt_r;

  // Result: level truncated toward zero, dead-zone lift, saturation flag.
  assign neg     = acc_r[ACC_W-1];
  assign mag     = neg ? $unsigned(-acc_r) : $unsigned(acc_r);
  assign pwm_mag = mag[F+15:F];
  assign pwm     = neg ? (16'd0 - pwm_mag) : pwm_mag;
  assign dz_s    = ACC_W'(cfg.dead_zone) << F;
  assign in_dz   = (mag != '0) && (mag < dz_s);

  always_comb begin
    res.pwm_level = pwm;
    res.saturated = (mag >= $unsigned(lim));
    if (in_dz) begin
      res.drive = neg ? (16'd0 - 16'(cfg.dead_zone)) : 16'(cfg.dead_zone);
    end else begin
      res.drive = pwm;
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
      fs_r   <= '0;
    end else begin
      acc_r  <= acc_nxt;
      prev_r <= prev_nxt;
      fs_r   <= fs_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    meas_r <= meas_nxt;
    tgt_r  <= tgt_nxt;
    prod_r <= prod_nxt;
    mac_r  <= mac_nxt;
    filt_r <= filt_nxt;
    err_r  <= err_nxt;
    sum_r  <= sum_nxt;
  end

endmodule

`default_nettype wire

### rtl/wheel_speed_pi_with_filter.sv
// Wheel speed PI controller with measurement low-pass filter and dead-zone lift.
// Top level: configuration registers, output register, wspf_seq and wspf_dp.
//
// Usage:
//   The in_ channel takes one word per control tick: in_tdata carries the
//   measured encoder count and the target speed, in_tuser marks a clear item
//   that zeroes the filter, the previous error and the drive accumulator.
//   The out_ channel returns one word per input word: drive, pwm_level and
//   the saturation flag. The cfg_ channel writes gains and limits by index
//   and is always ready; write it only while no item is in flight.
//   A control tick runs a ten-step program on one shared multiplier; a new
//   tick is accepted only once the last step has run. A clear item jumps
//   from the first step straight to a clear step that ends its program.
//   A finished word waits in the output register; the next item is still
//   accepted, and its final step holds until the receiver takes the old word.
//   Reset (rst_n low, synchronous) zeroes the controller state, loads the
//   register defaults and empties the output register.
`default_nettype none

module wheel_speed_pi_with_filter #(
  parameter int COUNT_WIDTH = wspf_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = wspf_pkg::FRAC_BITS_DEF,
  parameter int IN_TDATA_W  = ((2 * COUNT_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input words.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // measured_count, target_speed (from bit 0 up), zero padding
  input  wire logic [IN_TDATA_W-1:0]               in_tdata,
  // kind
  input  wire logic                                in_tuser,
  // Result words.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // drive, pwm_level, saturated (from bit 0 up), zero padding
  output logic [wspf_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // Configuration writes.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [wspf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wspf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  wspf_pkg::cfg_t  cfg_r, cfg_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [wspf_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  wspf_pkg::cw_t   cw;
  wspf_pkg::res_t  res;
  logic            busy;
  logic            start;
  logic            out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !busy;
  assign start      = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        wspf_pkg::REG_KP:    cfg_nxt.kp_gain      = cfg_data;
        wspf_pkg::REG_KI:    cfg_nxt.ki_gain      = cfg_data;
        wspf_pkg::REG_FILT:  cfg_nxt.filter_coeff = cfg_data[8:0];
        wspf_pkg::REG_DRIVE: cfg_nxt.drive_limit  = cfg_data[14:0];
        wspf_pkg::REG_DEAD:  cfg_nxt.dead_zone    = cfg_data[11:0];
        wspf_pkg::REG_SPEED: cfg_nxt.target_max   = cfg_data[11:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain      <= wspf_pkg::KP_RESET;
      cfg_r.ki_gain      <= wspf_pkg::KI_RESET;
      cfg_r.filter_coeff <= wspf_pkg::FILT_RESET;
      cfg_r.drive_limit  <= wspf_pkg::DRIVE_RESET;
      cfg_r.dead_zone    <= wspf_pkg::DEAD_RESET;
      cfg_r.target_max   <= wspf_pkg::SPEED_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer and datapath.
  wspf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .kind     (in_tuser),
    .out_free (out_free),
    .cw       (cw),
    .busy     (busy)
  );

  wspf_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (start),
    .meas_in   ($signed(in_tdata[COUNT_WIDTH-1:0])),
    .target_in ($signed(in_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH])),
    .cfg       (cfg_r),
    .cw        (cw),
    .res       (res)
  );

  // Output register: loaded by the last step of the program.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cw.last) begin
      out_valid_nxt = 1'b1;
      if (cw.clr) begin
        out_data_nxt = '0;
      end else begin
        out_data_nxt = wspf_pkg::OUT_TDATA_W'(res);
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> busy)
    else $error("accepted word did not start the program");

  a_last_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    cw.last |=> out_tvalid)
    else $error("final step did not present a result word");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.last && cw.clr) |=> (out_tdata == '0))
    else $error("clear item produced a nonzero result word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cw.last |-> (!out_valid_r || out_tready))
    else $error("result word overwritten before it was taken");
`endif

endmodule

`default_nettype wire

### sim/wheel_speed_pi_with_filter_test.sv
// Self-checking testbench for wheel_speed_pi_with_filter: filter, PI step, clamps, dead zone.
// Depends on wspf_pkg and the RTL top level only; predicts every result word in-bench.
`timescale 1ns / 1ps

module wheel_speed_pi_with_filter_test;

  localparam int COUNT_W    = wspf_pkg::COUNT_WIDTH_DEF;
  localparam int FRAC       = wspf_pkg::FRAC_BITS_DEF;
  localparam int IN_W       = ((2 * COUNT_W + 7) / 8) * 8;
  localparam int SETTLE     = 16;
  localparam int STALL_MAX  = 3000;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 152;

  typedef struct {
    logic                      clear;
    logic signed [COUNT_W-1:0] meas;
    logic signed [COUNT_W-1:0] target;
  } tick_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [wspf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [wspf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wspf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Controller settings as last written.
  logic [15:0] kp_gain      = wspf_pkg::KP_RESET;
  logic [15:0] ki_gain      = wspf_pkg::KI_RESET;
  logic [8:0]  filter_coeff = wspf_pkg::FILT_RESET;
  logic [14:0] drive_limit  = wspf_pkg::DRIVE_RESET;
  logic [11:0] dead_zone    = wspf_pkg::DEAD_RESET;
  logic [11:0] target_max   = wspf_pkg::SPEED_RESET;

  // Controller state, signed with FRAC fraction bits.
  longint lpf_state   = 0;
  longint last_error  = 0;
  longint drive_accum = 0;

  tick_t  tick_queue[$];
  wspf_pkg::res_t expected_drive_q[$];
  tick_t  held_tick;
  int     send_gap_pct = 0;
  int     recv_stall_pct = 0;
  int     error_count = 0;
  int     word_count = 0;
  int     quiet_cycles = 0;

  wheel_speed_pi_with_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // One control step: filter, incremental PI with anti-windup, clamp, dead-zone lift.
  function automatic wspf_pkg::res_t compute_drive(tick_t item);
    longint m, t, sl, c, filt, err, kp, ki, delta, lim, dz, pwm, drv;
    wspf_pkg::res_t r;
    r = '0;
    if (item.clear) begin
      lpf_state   = 0;
      last_error  = 0;
      drive_accum = 0;
      return r;
    end
    m  = item.meas;
    t  = item.target;
    sl = longint'(target_max);
    if (t > sl) t = sl;
    if (t < -sl) t = -sl;
    c = longint'(filter_coeff);
    if (c > 256) c = 256;
    filt = (c * (m <<< FRAC) + (256 - c) * lpf_state + wspf_pkg::ROUND_HALF)
           >>> wspf_pkg::GAIN_SHIFT;
    err  = (t <<< FRAC) - filt;
    kp    = longint'(kp_gain);
    ki    = longint'(ki_gain);
    delta = (kp * (err - last_error) + ki * err + wspf_pkg::ROUND_HALF)
            >>> wspf_pkg::GAIN_SHIFT;
    // The increment is refused when it would push further into saturation.
    lim = longint'(drive_limit) <<< FRAC;
    if (!((drive_accum >= lim && delta > 0) || (drive_accum <= -lim && delta < 0)))
      drive_accum += delta;
    if (drive_accum > lim) drive_accum = lim;
    if (drive_accum < -lim) drive_accum = -lim;
    last_error = err;
    lpf_state  = filt;
    // Integer part, truncated toward zero.
    if (drive_accum >= 0) pwm = drive_accum >>> FRAC;
    else pwm = -((-drive_accum) >>> FRAC);
    dz = longint'(dead_zone) <<< FRAC;
    if (drive_accum > 0 && drive_accum < dz) drv = longint'(dead_zone);
    else if (drive_accum < 0 && drive_accum > -dz) drv = -longint'(dead_zone);
    else if (drive_accum == 0) drv = 0;
    else drv = pwm;
    r.drive     = drv[15:0];
    r.pwm_level = pwm[15:0];
    r.saturated = (drive_accum >= lim) || (drive_accum <= -lim);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH word %0d %s: got %0d, expected %0d", word_count, what, got, want);
    error_count++;
  endtask

  // Driver: presents queued words, records each accepted one with its prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_drive_q.push_back(compute_drive(held_tick));
      if (!in_tvalid || in_tready) begin
        if (tick_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          held_tick = tick_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= held_tick.clear;
          in_tdata  <= {{(IN_W - 2 * COUNT_W){1'b0}}, held_tick.target, held_tick.meas};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    wspf_pkg::res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = wspf_pkg::res_t'(out_tdata[wspf_pkg::OUT_FIELDS_W-1:0]);
        if (expected_drive_q.size() == 0) begin
          report_mismatch("unexpected word, drive", longint'($signed(got.drive)), 0);
        end else begin
          want = expected_drive_q.pop_front();
          if (got.drive !== want.drive)
            report_mismatch("drive", longint'($signed(got.drive)),
                            longint'($signed(want.drive)));
          if (got.pwm_level !== want.pwm_level)
            report_mismatch("pwm_level", longint'($signed(got.pwm_level)),
                            longint'($signed(want.pwm_level)));
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", got.saturated, want.saturated);
        end
        word_count++;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_tick(input logic clear, input int meas, input int target);
    tick_t item;
    item.clear  = clear;
    item.meas   = meas[COUNT_W-1:0];
    item.target = target[COUNT_W-1:0];
    tick_queue.push_back(item);
  endtask

  function automatic int clip_count(input int v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  function automatic int any_count();
    return int'($urandom_range(8191)) - 4096;
  endfunction

  // Register write; the predictor keeps only the bits the register holds.
  task automatic write_reg(input wspf_pkg::reg_idx_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      wspf_pkg::REG_KP:    kp_gain      = value;
      wspf_pkg::REG_KI:    ki_gain      = value;
      wspf_pkg::REG_FILT:  filter_coeff = value[8:0];
      wspf_pkg::REG_DRIVE: drive_limit  = value[14:0];
      wspf_pkg::REG_DEAD:  dead_zone    = value[11:0];
      wspf_pkg::REG_SPEED: target_max   = value[11:0];
      default:   ;
    endcase
  endtask

  // Random register value of the given width, sometimes with junk above it.
  function automatic logic [15:0] pick_value(input int width, input int max_val);
    logic [15:0] v, junk;
    case ($urandom_range(3))
      0:       v = 16'(max_val);
      1:       v = 16'($urandom_range(max_val < 64 ? max_val : 64));
      default: v = 16'($urandom_range(max_val));
    endcase
    junk = 16'($urandom);
    if (width < 16 && $urandom_range(3) == 0)
      v = v | (junk & ~((16'd1 << width) - 16'd1));
    return v;
  endfunction

  task automatic load_settings(input int p);
    case (p)
      0, 6: begin
        write_reg(wspf_pkg::REG_KP, 16'hFFFF);
        write_reg(wspf_pkg::REG_KI, 16'hFFFF);
        write_reg(wspf_pkg::REG_FILT, 16'd511);
        write_reg(wspf_pkg::REG_DRIVE, 16'd32767);
        write_reg(wspf_pkg::REG_DEAD, 16'd4095);
        write_reg(wspf_pkg::REG_SPEED, 16'd4095);
      end
      1, 9: begin
        write_reg(wspf_pkg::REG_KP, 16'd0);
        write_reg(wspf_pkg::REG_KI, 16'd0);
        write_reg(wspf_pkg::REG_FILT, 16'd0);
        write_reg(wspf_pkg::REG_DRIVE, 16'd0);
        write_reg(wspf_pkg::REG_DEAD, 16'd0);
        write_reg(wspf_pkg::REG_SPEED, 16'd0);
      end
      // Dead zone far above a tight drive limit, new sample only, low target clamp.
      2: begin
        write_reg(wspf_pkg::REG_KP, wspf_pkg::KP_RESET);
        write_reg(wspf_pkg::REG_KI, wspf_pkg::KI_RESET);
        write_reg(wspf_pkg::REG_FILT, 16'd256);
        write_reg(wspf_pkg::REG_DRIVE, 16'd40);
        write_reg(wspf_pkg::REG_DEAD, 16'd4095);
        write_reg(wspf_pkg::REG_SPEED, 16'd100);
      end
      3: begin
        write_reg(wspf_pkg::REG_KP, wspf_pkg::KP_RESET);
        write_reg(wspf_pkg::REG_KI, wspf_pkg::KI_RESET);
        write_reg(wspf_pkg::REG_FILT, 16'(wspf_pkg::FILT_RESET));
        write_reg(wspf_pkg::REG_DRIVE, 16'(wspf_pkg::DRIVE_RESET));
        write_reg(wspf_pkg::REG_DEAD, 16'(wspf_pkg::DEAD_RESET));
        write_reg(wspf_pkg::REG_SPEED, 16'(wspf_pkg::SPEED_RESET));
      end
      default: begin
        write_reg(wspf_pkg::REG_KP, pick_value(16, 65535));
        write_reg(wspf_pkg::REG_KI, pick_value(16, 65535));
        write_reg(wspf_pkg::REG_FILT, pick_value(9, 511));
        write_reg(wspf_pkg::REG_DRIVE, pick_value(15, 32767));
        write_reg(wspf_pkg::REG_DEAD, pick_value(12, 4095));
        write_reg(wspf_pkg::REG_SPEED, pick_value(12, 4095));
      end
    endcase
  endtask

  // Runs of a held target with the measurement tracking it, plus clears and noise.
  task automatic queue_run(input int count);
    int n, hold, roll, target, spread;
    hold   = 0;
    target = 0;
    spread = 8;
    for (n = 0; n < count; n++) begin
      if (hold == 0) begin
        hold   = $urandom_range(30, 4);
        spread = 1 << $urandom_range(9);
        case ($urandom_range(3))
          0:       target = any_count();
          1:       target = int'($urandom_range(128)) - 64;
          2:       target = 0;
          default: target = int'($urandom_range(2000)) - 1000;
        endcase
      end
      hold--;
      roll = $urandom_range(99);
      if (roll < 4)
        queue_tick(1'b1, any_count(), any_count());
      else if (roll < 20)
        queue_tick(1'b0, any_count(), any_count());
      else
        queue_tick(1'b0, clip_count(target + int'($urandom_range(2 * spread)) - spread),
                   target);
    end
  endtask

  task automatic wait_idle();
    while (tick_queue.size() > 0 || in_tvalid || expected_drive_q.size() > 0)
      @(posedge clk);
  endtask

  // Stimulus sequencing: directed words at the reset settings, then random phases.
  initial begin
    int p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct   = 23;
    recv_stall_pct = 81;

    // Clears, dead-zone lift both ways, saturation and windup, field extremes.
    queue_tick(1'b1, 4095, -4096);
    queue_tick(1'b0, 0, 0);
    queue_tick(1'b0, 0, 1);
    queue_tick(1'b1, 0, 0);
    queue_tick(1'b0, 0, -1);
    repeat (4) queue_tick(1'b0, -4096, 4095);
    repeat (4) queue_tick(1'b0, 4095, -4096);
    queue_tick(1'b0, 4095, 4095);
    queue_tick(1'b0, -4096, -4096);
    queue_tick(1'b1, -4096, 4095);
    queue_tick(1'b0, 100, 100);
    queue_tick(1'b0, -1, 0);
    queue_tick(1'b0, 1, 0);
    queue_tick(1'b0, 2730, -2731);
    queue_tick(1'b0, -2731, 2730);
    queue_tick(1'b1, -1, -1);
    queue_tick(1'b0, 5, 3);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_gap_pct   = 81;
        recv_stall_pct = 23;
      end else if (p == 2 * PHASES / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      repeat (SETTLE) @(posedge clk);
      load_settings(p);
      queue_run(PHASE_LEN);
      wait_idle();
    end

    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && expected_drive_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### wheel_speed_pi_with_filter.f
rtl/wspf_pkg.sv
rtl/wspf_seq.sv
rtl/wspf_dp.sv
rtl/wheel_speed_pi_with_filter.sv
sim/wheel_speed_pi_with_filter_test.sv
